// File: design/xfd_pkg.sv
// ----------------------------------------------------------------------------
// xfd_pkg
// Types and constants shared by the XOR frame deframer.
// ----------------------------------------------------------------------------
package xfd_pkg;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_ID      = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHECK   = 3'd4
	} phase_t;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;
	localparam logic              REG_START_BYTE = 1'b0;

	typedef struct packed {
		logic [OUT_DATA_W-26:0] pad;
		logic                   check_ok;
		logic [BYTE_W-1:0]      frame_length;
		logic [BYTE_W-1:0]      source_id;
		logic [BYTE_W-1:0]      data_byte;
	} out_word_t;

endpackage

// File: design/xor_frame_deframer.sv
// ----------------------------------------------------------------------------
// xor_frame_deframer
// Extracts length-prefixed frames with an XOR check byte from a byte stream.
// ----------------------------------------------------------------------------
// The input stream carries one received byte per beat. A frame is a start
// byte, a device id, a payload length, that many payload bytes and a check
// byte equal to the XOR of all earlier frame bytes. Bytes outside a frame
// are dropped. Each payload byte leaves as one output beat with tlast low;
// the check byte produces one beat with tlast high that reports the id,
// the length and whether the check matched. Header bytes produce no beat.
// Every byte is handled in the cycle it is taken, so a result appears in the
// cycle after its input beat and one byte per cycle is sustained while the
// output side is ready. The output register holds a result while the
// receiver stalls, and the input is taken again as soon as it drains.
// The start byte register is written through the APB port at address 0.
// Reset returns the block to hunting with an empty output register and
// the start byte set to 0xAA.
// ----------------------------------------------------------------------------
module xor_frame_deframer
	import xfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,  // rx_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // data_byte, source_id, frame_length, check_ok
	output logic                  m_axis_tlast,  // is_end
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] held_id_q, held_id_d;
	logic [BYTE_W-1:0] held_length_q, held_length_d;
	logic [BYTE_W-1:0] bytes_left_q, bytes_left_d;
	logic [BYTE_W-1:0] running_xor_q, running_xor_d;
	logic              out_valid_q;
	logic              out_last_q;
	out_word_t         out_word_q, res_word;
	logic              res_valid, res_last;
	logic              in_fire;
	logic [BYTE_W-1:0] b;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_START_BYTE) ?
		{{(APB_DATA_W-BYTE_W){1'b0}}, start_byte_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_START_BYTE) begin
			start_byte_q <= pwdata[BYTE_W-1:0];
		end
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_ID:      phase_d = PH_LEN;
			PH_LEN:     phase_d = (b == '0) ? PH_CHECK : PH_PAYLOAD;
			PH_PAYLOAD: phase_d = (bytes_left_q == 8'd1) ? PH_CHECK : PH_PAYLOAD;
			PH_CHECK:   phase_d = PH_HUNT;
			default:    phase_d = (b == start_byte_q) ? PH_ID : PH_HUNT;
		endcase
	end

	always_comb begin
		held_id_d     = held_id_q;
		held_length_d = held_length_q;
		bytes_left_d  = bytes_left_q;
		running_xor_d = running_xor_q;
		res_valid     = 1'b0;
		res_last      = 1'b0;
		res_word      = '0;
		res_word.source_id    = held_id_q;
		res_word.frame_length = held_length_q;
		unique case (phase_q)
			PH_ID: begin
				held_id_d     = b;
				running_xor_d = running_xor_q ^ b;
			end
			PH_LEN: begin
				held_length_d = b;
				bytes_left_d  = b;
				running_xor_d = running_xor_q ^ b;
			end
			PH_PAYLOAD: begin
				running_xor_d      = running_xor_q ^ b;
				bytes_left_d       = bytes_left_q - 8'd1;
				res_valid          = 1'b1;
				res_word.data_byte = b;
			end
			PH_CHECK: begin
				res_valid         = 1'b1;
				res_last          = 1'b1;
				res_word.check_ok = (b == running_xor_q);
				running_xor_d     = '0;
				bytes_left_d      = '0;
			end
			default: begin
				if (b == start_byte_q) begin
					running_xor_d = b;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			held_id_q     <= '0;
			held_length_q <= '0;
			bytes_left_q  <= '0;
			running_xor_q <= '0;
		end else if (in_fire) begin
			phase_q       <= phase_d;
			held_id_q     <= held_id_d;
			held_length_q <= held_length_d;
			bytes_left_q  <= bytes_left_d;
			running_xor_q <= running_xor_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= in_fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			out_word_q <= res_word;
			out_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_word_q;
	assign m_axis_tlast  = out_last_q;

	a_check_gives_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && phase_q == PH_CHECK |=> m_axis_tvalid && m_axis_tlast)
		else $error("check byte did not produce an end beat");

	a_payload_passes: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && phase_q == PH_PAYLOAD |=> m_axis_tvalid && !m_axis_tlast
			&& m_axis_tdata[BYTE_W-1:0] == $past(s_axis_tdata))
		else $error("payload byte not passed on");

	a_header_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (phase_q == PH_HUNT || phase_q == PH_ID || phase_q == PH_LEN)
			|=> !m_axis_tvalid)
		else $error("header or idle byte produced a beat");

	a_end_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[BYTE_W-1:0] == '0)
		else $error("end beat carries a data byte");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> bytes_left_q != '0)
		else $error("payload phase with no bytes left");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the XOR frame deframer.
// ----------------------------------------------------------------------------
// Received bytes are streamed in and both stream sides idle at random. A
// frame tracker mirrors the deframing on every accepted byte and checks each
// output beat field by field against the oldest beat it expects. A directed
// opening covers the edge cases, after which random frames with mostly small
// payloads and a few full-length ones run under several start byte settings.
// ----------------------------------------------------------------------------
module testbench;
	import xfd_pkg::*;

	localparam int unsigned                 CYCLE_LIMIT  = 400000;
	localparam int unsigned                 ITEM_TARGET  = 2000;
	localparam logic [APB_ADDR_W-1:0]       START_ADDR   = APB_ADDR_W'(4 * REG_START_BYTE);
	localparam logic [APB_ADDR_W-1:0]       UNUSED_ADDR  = APB_ADDR_W'(4);

	typedef struct {
		logic              is_end;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] source_id;
		logic [BYTE_W-1:0] frame_length;
		logic              check_ok;
	} deframed_beat_t;

	class frame_tracker;
		logic [BYTE_W-1:0] start_byte;
		phase_t            phase;
		logic [BYTE_W-1:0] held_id;
		logic [BYTE_W-1:0] held_length;
		logic [BYTE_W-1:0] bytes_left;
		logic [BYTE_W-1:0] running_xor;
		deframed_beat_t    expected_beats[$];
		int unsigned       mismatches;

		function new();
			start_byte  = START_BYTE_RST;
			phase       = PH_HUNT;
			held_id     = '0;
			held_length = '0;
			bytes_left  = '0;
			running_xor = '0;
			mismatches  = 0;
		endfunction

		function void set_start(logic [BYTE_W-1:0] value);
			start_byte = value;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function void take_byte(logic [BYTE_W-1:0] b);
			deframed_beat_t beat;
			case (phase)
				PH_ID: begin
					held_id     = b;
					running_xor = running_xor ^ b;
					phase       = PH_LEN;
				end
				PH_LEN: begin
					held_length = b;
					bytes_left  = b;
					running_xor = running_xor ^ b;
					phase       = (b == '0) ? PH_CHECK : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					running_xor = running_xor ^ b;
					bytes_left  = bytes_left - 1'b1;
					if (bytes_left == '0)
						phase = PH_CHECK;
					beat.is_end       = 1'b0;
					beat.data_byte    = b;
					beat.source_id    = held_id;
					beat.frame_length = held_length;
					beat.check_ok     = 1'b0;
					expected_beats.insert(expected_beats.size(), beat);
				end
				PH_CHECK: begin
					beat.is_end       = 1'b1;
					beat.data_byte    = '0;
					beat.source_id    = held_id;
					beat.frame_length = held_length;
					beat.check_ok     = (b == running_xor);
					expected_beats.insert(expected_beats.size(), beat);
					phase       = PH_HUNT;
					running_xor = '0;
					bytes_left  = '0;
				end
				default: begin
					phase = PH_HUNT;
					if (b == start_byte) begin
						running_xor = b;
						phase       = PH_ID;
					end
				end
			endcase
		endfunction

		function void check_beat(logic [OUT_DATA_W-1:0] word, logic last);
			out_word_t      got;
			deframed_beat_t exp_beat;
			got = word;
			if (expected_beats.size() == 0) begin
				$error("Unexpected output beat: tdata %08h, tlast %0b", word, last);
				mismatches++;
				return;
			end
			exp_beat = expected_beats[0];
			expected_beats.delete(0);
			if (last !== exp_beat.is_end) begin
				$error("is_end: expected %0h, actual %0h", exp_beat.is_end, last);
				mismatches++;
			end
			if (got.data_byte !== exp_beat.data_byte) begin
				$error("data_byte: expected %0h, actual %0h", exp_beat.data_byte,
					got.data_byte);
				mismatches++;
			end
			if (got.source_id !== exp_beat.source_id) begin
				$error("source_id: expected %0h, actual %0h", exp_beat.source_id,
					got.source_id);
				mismatches++;
			end
			if (got.frame_length !== exp_beat.frame_length) begin
				$error("frame_length: expected %0h, actual %0h", exp_beat.frame_length,
					got.frame_length);
				mismatches++;
			end
			if (got.check_ok !== exp_beat.check_ok) begin
				$error("check_ok: expected %0h, actual %0h", exp_beat.check_ok,
					got.check_ok);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	frame_tracker          tracker;
	logic [BYTE_W-1:0]     cur_start;
	logic                  calm;
	int unsigned           cycles;
	int unsigned           items;

	xor_frame_deframer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.take_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_beat(m_axis_tdata, m_axis_tlast);
			if (psel && penable && pwrite && pready && paddr == START_ADDR)
				tracker.set_start(pwdata[BYTE_W-1:0]);
		end
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	// The receiver draws a fresh stall before every beat it takes.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_start_reg();
		logic [APB_DATA_W-1:0] rd;
		apb_access(1'b0, START_ADDR, '0, rd);
		if (rd[BYTE_W-1:0] !== cur_start) begin
			$error("start_byte: expected %0h, actual %0h", cur_start, rd[BYTE_W-1:0]);
			tracker.mismatches++;
		end
	endtask

	task automatic write_start(input logic [BYTE_W-1:0] value);
		logic [APB_DATA_W-1:0] rd;
		apb_access(1'b1, START_ADDR, APB_DATA_W'(value), rd);
		cur_start = value;
		check_start_reg();
	endtask

	task automatic send_frame(input int unsigned len, input bit good_check);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		sum = cur_start;
		send_byte(cur_start);
		b = BYTE_W'($urandom);
		send_byte(b);
		sum ^= b;
		send_byte(BYTE_W'(len));
		sum ^= BYTE_W'(len);
		for (int i = 0; i < len; i++) begin
			b = ($urandom_range(0, 7) == 0) ? cur_start : BYTE_W'($urandom);
			send_byte(b);
			sum ^= b;
		end
		send_byte(good_check ? sum : BYTE_W'($urandom));
		items += len + 4;
	endtask

	task automatic send_noise();
		logic [BYTE_W-1:0] b;
		repeat ($urandom_range(1, 3)) begin
			do b = BYTE_W'($urandom); while (b == cur_start);
			send_byte(b);
		end
	endtask

	initial begin
		logic [APB_DATA_W-1:0] rd;
		int unsigned           frames;
		int unsigned           setting;
		logic [BYTE_W-1:0]     pick;

		tracker       = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		cycles        = 0;
		items         = 0;
		calm          = 1'b0;
		cur_start     = START_BYTE_RST;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_start_reg();

		// Directed opening: dropped byte, empty frame, full-range header values,
		// the start byte inside a payload and a failing check.
		send_byte(8'h55);
		send_byte(8'hAA); send_byte(8'h00); send_byte(8'h00); send_byte(8'hAA);
		send_byte(8'hAA); send_byte(8'hFF); send_byte(8'h02);
		send_byte(8'hAA); send_byte(8'hFF); send_byte(8'hAA ^ 8'hFF ^ 8'h02 ^ 8'hAA ^ 8'hFF);
		send_byte(8'hAA); send_byte(8'h12); send_byte(8'h01); send_byte(8'h00);
		send_byte(8'h00);

		// The start byte changes after the id of a frame has arrived; the frame
		// in flight keeps the old value in its check.
		send_byte(8'hAA); send_byte(8'h34);
		drain();
		write_start(8'h5A);
		apb_access(1'b1, UNUSED_ADDR, 32'h0000_0000, rd);
		check_start_reg();
		send_byte(8'h01); send_byte(8'h5A);
		send_byte(8'hAA ^ 8'h34 ^ 8'h01 ^ 8'h5A);
		items = 0;

		drain();
		write_start(8'hAA);
		send_frame(255, 1'b1);

		frames  = 0;
		setting = 0;
		while (items < ITEM_TARGET) begin
			if (frames % 30 == 29) begin
				drain();
				case (setting % 4)
					0:       pick = 8'h00;
					1:       pick = 8'hFF;
					2:       pick = 8'hAA;
					default: pick = BYTE_W'($urandom);
				endcase
				setting++;
				write_start(pick);
			end
			if (frames % 10 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (frames == 120)
				send_frame(255, 1'b0);
			if ($urandom_range(0, 3) == 0)
				send_noise();
			if ($urandom_range(0, 19) == 0)
				send_byte(cur_start);
			send_frame(($urandom_range(0, 39) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 7), $urandom_range(0, 2) != 0);
			frames++;
		end

		drain();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
